// File: rtl/core/fifo_with_delete_by_value_unit_defines.svh
// Assertion macros used by the top RTL file of the delete-by-value queue.
`ifndef FIFO_WITH_DELETE_BY_VALUE_UNIT_DEFINES_SVH
`define FIFO_WITH_DELETE_BY_VALUE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FDEL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FDEL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDEL_ASSERT(lbl, clk, rst, prop, msg)
`define FDEL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/fdel_pkg.sv
package fdel_pkg;

   localparam int CMD_W  = 2;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 5;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [DATA_W-1:0] data_out;
      logic [LEN_W-1:0]  length;
   } rsp_type;

   typedef struct packed {
      logic occupied;
      logic enq_here;
      logic deq;
      logic del;
   } cell_ctl_type;

endpackage

// File: rtl/core/fifo_with_delete_by_value_unit.sv
// Ordered queue of nonzero words with delete by value.
// A request (cmd, value) is taken on a clock edge where start is high and busy
// is low. Enqueue appends a word, dequeue returns the oldest word, and delete
// removes the oldest entry equal to the word while keeping the order of the rest.
// Each request gives exactly one response on rsp, marked by rsp_valid for one
// cycle, in the cycle after the request is taken.
// A new request may be taken in every cycle, so the throughput is one request
// per cycle; the row of cells compares and shifts all entries in that cycle.
// The response reports status (error for a full or empty queue, a zero word, a
// word not found or an unused command), the dequeued word, and the length after
// the request. Reset empties the queue; busy is high only while reset is high.
// The receiver cannot stall: a response is valid for its single cycle only.
`include "fifo_with_delete_by_value_unit_defines.svh"

module fifo_with_delete_by_value_unit
   import fdel_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  accept;
   logic [WORD_WIDTH-1:0] word;
   logic                  word_nz;
   logic                  enq_ok;
   logic                  deq_ok;
   logic                  del_go;
   logic                  del_ok;
   logic                  ok;

   logic [WORD_WIDTH-1:0] words [DEPTH];
   logic                  seen  [DEPTH+1];
   cell_ctl_type          ctl   [DEPTH];

   assign busy    = reset;
   assign accept  = start && !busy;
   assign word    = WORD_WIDTH'(req.value);
   assign word_nz = (word != '0);

   assign enq_ok = accept && (req.cmd == CMD_ENQUEUE) && word_nz
                   && (count_ff != CNT_W'(DEPTH));
   assign deq_ok = accept && (req.cmd == CMD_DEQUEUE) && (count_ff != '0);
   assign del_go = accept && (req.cmd == CMD_DELETE) && word_nz;
   assign del_ok = seen[DEPTH];
   assign ok     = enq_ok || deq_ok || del_ok;

   assign seen[0] = 1'b0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [WORD_WIDTH-1:0] next_word;

      assign ctl[k].occupied = (count_ff > CNT_W'(k));
      assign ctl[k].enq_here = enq_ok && (count_ff == CNT_W'(k));
      assign ctl[k].deq      = deq_ok;
      assign ctl[k].del      = del_go;

      if (k == DEPTH - 1) begin : g_last
         assign next_word = words[k];
      end else begin : g_mid
         assign next_word = words[k+1];
      end

      fdel_cell #(
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl[k]),
         .value     (word),
         .next_word (next_word),
         .seen_in   (seen[k]),
         .seen_out  (seen[k+1]),
         .word      (words[k])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok || del_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_valid_in    = accept;
      rsp_in.status   = !ok;
      rsp_in.data_out = deq_ok ? DATA_W'(words[0]) : '0;
      rsp_in.length   = LEN_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `FDEL_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "count above depth")
   `FDEL_ASSERT(a_one_response, clock, reset, accept |=> rsp_valid_ff, "response missing")
   `FDEL_ASSERT(a_no_spurious, clock, reset, !accept |=> !rsp_valid_ff, "spurious response")
   `FDEL_ASSERT(a_error_keeps_count, clock, reset,
      (rsp_valid_ff && rsp_ff.status) |-> (count_ff == $past(count_ff)), "error changed count")
   `FDEL_ASSERT(a_deq_shrinks, clock, reset,
      deq_ok |=> (count_ff == $past(count_ff) - CNT_W'(1)), "dequeue count")
   `FDEL_ASSERT_ALWAYS(a_busy_in_reset, clock,
      reset |-> (busy && !accept), "request taken in reset")

endmodule

// File: rtl/core/fdel_cell.sv
module fdel_cell
   import fdel_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [WORD_WIDTH-1:0] value,
   input  logic [WORD_WIDTH-1:0] next_word,
   input  logic                  seen_in,
   output logic                  seen_out,
   output logic [WORD_WIDTH-1:0] word
);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;
   logic                  hit;

   assign hit      = ctl.del && ctl.occupied && (word_ff == value);
   assign seen_out = seen_in || hit;
   assign word     = word_ff;

   // Dequeue, or delete at/behind the removed entry, takes the younger neighbor's word.
   always_comb begin
      priority if (ctl.enq_here) begin
         word_in = value;
      end else if (ctl.deq || (ctl.del && seen_out)) begin
         word_in = next_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// File: verif/tb_fifo_with_delete_by_value_unit.sv
module tb_fifo_with_delete_by_value_unit;
   import fdel_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_kind;

   typedef struct {
      bit      pause;
      req_type payload;
   } send_slot;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    rsp_valid;
   rsp_type rsp;

   send_slot          requests_to_send[$];
   rsp_type           responses_due[$];
   logic [DATA_W-1:0] words_held[$];

   int requests_taken = 0;
   int responses_checked = 0;
   int mismatches = 0;
   int full_rejects = 0;
   int empty_rejects = 0;
   int delete_hits = 0;

   fifo_with_delete_by_value_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp(rsp)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type service_request(req_type r);
      rsp_type o;
      int      hit;
      o.status = 1'b1;
      o.data_out = '0;
      hit = -1;
      case (r.cmd)
         CMD_ENQUEUE: begin
            if (r.value != '0 && words_held.size() < QUEUE_DEPTH) begin
               words_held.push_back(r.value);
               o.status = 1'b0;
            end else if (r.value != '0) begin
               full_rejects++;
            end
         end
         CMD_DEQUEUE: begin
            if (words_held.size() > 0) begin
               o.data_out = words_held.pop_front();
               o.status = 1'b0;
            end else begin
               empty_rejects++;
            end
         end
         CMD_DELETE: begin
            if (r.value != '0) begin
               for (int k = 0; k < words_held.size(); k++) begin
                  if (hit < 0 && words_held[k] == r.value) hit = k;
               end
               if (hit >= 0) begin
                  words_held.delete(hit);
                  o.status = 1'b0;
                  delete_hits++;
               end
            end
         end
         default: ;
      endcase
      o.length = LEN_W'(words_held.size());
      return o;
   endfunction

   task automatic add_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
      send_slot s;
      s.pause = 1'b0;
      s.payload.cmd = cmd;
      s.payload.value = value;
      requests_to_send.push_back(s);
   endtask

   task automatic add_pause();
      send_slot s;
      s.pause = 1'b1;
      s.payload = '0;
      requests_to_send.push_back(s);
   endtask

   task automatic note_mismatch(string what, logic [DATA_W-1:0] got,
                                logic [DATA_W-1:0] want);
      $display("mismatch on %s: got %h, expected %h (response %0d)",
               what, got, want, responses_checked);
      mismatches++;
   endtask

   always @(posedge clock) begin : drive
      send_slot head;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            responses_due.push_back(service_request(req));
            requests_taken++;
         end
         if (requests_to_send.size() != 0 && requests_to_send[0].pause) begin
            start <= 1'b0;
            if (responses_due.size() == 0) void'(requests_to_send.pop_front());
         end else if (requests_to_send.size() != 0 &&
                      ((requests_taken >= 700 && requests_taken < 1000) ||
                       $urandom_range(99) >= 37)) begin
            head = requests_to_send.pop_front();
            req <= head.payload;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (responses_due.size() == 0) begin
            note_mismatch("unrequested response", rsp.data_out, '0);
         end else begin
            want = responses_due.pop_front();
            if (rsp.status !== want.status)
               note_mismatch("status", DATA_W'(rsp.status), DATA_W'(want.status));
            if (rsp.data_out !== want.data_out)
               note_mismatch("data_out", rsp.data_out, want.data_out);
            if (rsp.length !== want.length)
               note_mismatch("length", DATA_W'(rsp.length), DATA_W'(want.length));
         end
         responses_checked++;
      end
   end

   initial begin
      logic [DATA_W-1:0] pool[8];
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] value;
      mix_kind           mix;
      int                roll;

      add_request(CMD_ENQUEUE, 32'h0);
      add_request(CMD_DEQUEUE, 32'h0);
      add_request(CMD_DELETE, 32'h5);
      add_request(CMD_UNUSED, 32'h7);
      add_request(CMD_DELETE, 32'h0);
      add_request(CMD_ENQUEUE, 32'hFFFF_FFFF);
      add_request(CMD_ENQUEUE, 32'h1);
      add_request(CMD_ENQUEUE, 32'h8000_0000);
      add_request(CMD_ENQUEUE, 32'h1);
      add_request(CMD_DELETE, 32'h1);
      add_request(CMD_DELETE, 32'h1234);
      add_request(CMD_DEQUEUE, 32'hFFFF_FFFF);
      for (int k = 0; k < 14; k++) add_request(CMD_ENQUEUE, 32'h3 << (2 * k));
      add_request(CMD_ENQUEUE, 32'hA5A5_A5A5);
      add_pause();

      for (int phase = 0; phase < 17; phase++) begin
         mix = mix_kind'($urandom_range(2));
         foreach (pool[k]) begin
            pool[k] = $urandom;
            if (pool[k] == '0) pool[k] = 32'h1;
         end
         for (int n = 0; n < 100; n++) begin
            roll = $urandom_range(99);
            if (roll < 2)
               cmd = CMD_UNUSED;
            else if (mix == MIX_FILL)
               cmd = roll < 75 ? CMD_ENQUEUE : roll < 87 ? CMD_DEQUEUE : CMD_DELETE;
            else if (mix == MIX_DRAIN)
               cmd = roll < 25 ? CMD_ENQUEUE : roll < 65 ? CMD_DEQUEUE : CMD_DELETE;
            else
               cmd = roll < 45 ? CMD_ENQUEUE : roll < 70 ? CMD_DEQUEUE : CMD_DELETE;
            roll = $urandom_range(99);
            value = roll < 3 ? '0 : roll < 90 ? pool[$urandom_range(7)] : $urandom;
            add_request(cmd, value);
         end
         if (phase == 8) add_pause();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (requests_to_send.size() != 0 || start || responses_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Covered %0d requests and %0d responses; %0d deletes found their word.",
               requests_taken, responses_checked, delete_hits);
      $display("Enqueues refused on a full store: %0d; dequeues on an empty one: %0d.",
               full_rejects, empty_rejects);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #4800000;
      $display("Timed out with %0d requests taken.", requests_taken);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
